### src/kmp_pkg.sv
// Shared constants and types for the streaming pattern matcher.
package kmp_pkg;

  localparam int unsigned MAX_PATTERN_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 32;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_REG_W  = 5;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned START_W    = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_DATA_W = START_W + COUNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic clear;
    logic advance;
  } cell_ctrl_t;

endpackage

### src/kmp_cell.sv
// One cell of the prefix chain: tracks whether the pattern prefix up to its byte is matched.
module kmp_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kmp_pkg::cell_ctrl_t            ctrl_i,
  input  logic [kmp_pkg::BYTE_W-1:0]     text_byte_i,
  input  logic [kmp_pkg::BYTE_W-1:0]     pat_byte_i,
  input  logic                           prev_hit_i,
  output logic                           hit_next_o,
  output logic                           hit_o
);

  logic hit_q, hit_d;

  assign hit_next_o = prev_hit_i && (text_byte_i == pat_byte_i);

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.clear) begin
      hit_d = 1'b0;
    end else if (ctrl_i.advance) begin
      hit_d = hit_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

### src/kmp_all_matches.sv
// Top level of the streaming matcher: config registers, cell chain, counters, output register.
// A result is registered and presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; every cell compares its pattern byte in that cycle.
// A result held by the receiver stalls the input; the next byte enters in the cycle it is taken.
// Reset clears the cells, position, count and pattern; pattern length resets to 1.
module kmp_all_matches #(
  parameter int unsigned MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // text_byte
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [kmp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // match_start[31:0], match_total[63:32]
  output logic                               m_axis_tuser,  // match_found
  output logic                               m_axis_tlast
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned SUB_W = (POSITION_BITS > kmp_pkg::START_W) ? POSITION_BITS
                                                                     : kmp_pkg::START_W;

  logic [kmp_pkg::CFG_DATA_W-1:0] pat_low_q, pat_high_q;
  logic [kmp_pkg::LEN_REG_W-1:0]  len_q;
  logic [POSITION_BITS-1:0]       pos_q, pos_d;
  logic [kmp_pkg::COUNT_W-1:0]    count_q, count_d;

  logic                           out_valid_q;
  logic [kmp_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                           out_user_q, out_last_q;

  logic                 accept, cfg_hit, found;
  logic [LEN_W-1:0]     eff_len;
  logic [IDX_W-1:0]     last_idx;
  logic [MAX_PATTERN-1:0] hit_next, hit;
  logic [SUB_W-1:0]     start_full;
  kmp_pkg::cell_ctrl_t  ctrl;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_hit       = cfg_we_i && ((cfg_index_i == kmp_pkg::CFG_PAT_LOW)
                                   || (cfg_index_i == kmp_pkg::CFG_PAT_HIGH)
                                   || (cfg_index_i == kmp_pkg::CFG_PAT_LEN));

  assign ctrl = '{clear: cfg_hit || (accept && s_axis_tlast), advance: accept};

  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_q) > MAX_PATTERN) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(len_q);
    end
    last_idx = IDX_W'(eff_len - LEN_W'(1));
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic [kmp_pkg::BYTE_W-1:0] pat_byte;
    logic                       prev_hit;
    if (g < 8) begin : g_low
      assign pat_byte = pat_low_q[8*g +: 8];
    end else if (g < 16) begin : g_high
      assign pat_byte = pat_high_q[8*(g-8) +: 8];
    end else begin : g_zero
      assign pat_byte = '0;
    end
    if (g == 0) begin : g_first
      assign prev_hit = 1'b1;
    end else begin : g_rest
      assign prev_hit = hit[g-1];
    end
    kmp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .text_byte_i (s_axis_tdata),
      .pat_byte_i  (pat_byte),
      .prev_hit_i  (prev_hit),
      .hit_next_o  (hit_next[g]),
      .hit_o       (hit[g])
    );
  end

  assign found = hit_next[last_idx];

  always_comb begin
    if (pos_q >= POSITION_BITS'(eff_len - LEN_W'(1))) begin
      start_full = SUB_W'(pos_q) - SUB_W'(eff_len - LEN_W'(1));
    end else begin
      start_full = '0;
    end
    if (!found) begin
      start_full = '0;
    end
    count_d = count_q;
    if (found && (count_q != '1)) begin
      count_d = count_q + kmp_pkg::COUNT_W'(1);
    end
    pos_d = pos_q;
    if (pos_q != '1) begin
      pos_d = pos_q + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      len_q      <= kmp_pkg::LEN_REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kmp_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        kmp_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        kmp_pkg::CFG_PAT_LEN:  len_q      <= cfg_data_i[kmp_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        pos_q   <= '0;
        count_q <= '0;
      end else begin
        pos_q   <= pos_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {count_d, start_full[kmp_pkg::START_W-1:0]};
      out_user_q <= found;
      out_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  a_end_clears_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> (pos_q == '0) && (count_q == '0))
    else $error("position or count not cleared at end of text");

  a_cfg_clears_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (hit == '0))
    else $error("cells not cleared by pattern write");

  a_no_match_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[kmp_pkg::START_W-1:0] == '0))
    else $error("nonzero start without match");

  a_match_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[kmp_pkg::OUT_DATA_W-1:kmp_pkg::START_W] != '0))
    else $error("match reported with zero total");

endmodule
